// ===== design/latlon_flat_earth_distance_macros.svh =====
// assertion macros shared by the flat-earth distance block
`ifndef LATLON_FLAT_EARTH_DISTANCE_MACROS_SVH
`define LATLON_FLAT_EARTH_DISTANCE_MACROS_SVH
`ifndef SYNTH
`define LFED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfed check failed");
`define LFED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfed check failed");
`else
`define LFED_ASSERT_IMP(lbl, ante, cons)
`define LFED_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/lfed_pkg.sv =====
// package: types, constants and helper functions for the flat-earth distance block
package lfed_pkg;

    localparam int COS_FRAC_BITS_DEF = 18;
    localparam logic [31:0] CM_RESET = 32'd1195276997;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint QUARTER_TURN = 900000000;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;
    localparam int TAG_W = 66;
    localparam int RES_W = 99;

    typedef struct packed {
        logic signed [31:0] dlat;
        logic signed [31:0] dlon;
        logic [30:0]        amean;
        logic               beyond;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // arctangent of 2^-i in 1e-7 degree
    function automatic logic [31:0] atan_deg7(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd450000000;
            1:  r = 32'd265650512;
            2:  r = 32'd140362435;
            3:  r = 32'd71250163;
            4:  r = 32'd35763344;
            5:  r = 32'd17899106;
            6:  r = 32'd8951737;
            7:  r = 32'd4476142;
            8:  r = 32'd2238105;
            9:  r = 32'd1119057;
            10: r = 32'd559529;
            11: r = 32'd279765;
            12: r = 32'd139882;
            13: r = 32'd69941;
            14: r = 32'd34971;
            15: r = 32'd17485;
            16: r = 32'd8743;
            17: r = 32'd4371;
            18: r = 32'd2186;
            19: r = 32'd1093;
            20: r = 32'd546;
            21: r = 32'd273;
            22: r = 32'd137;
            23: r = 32'd68;
            24: r = 32'd34;
            25: r = 32'd17;
            26: r = 32'd9;
            27: r = 32'd4;
            28: r = 32'd2;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

    // cordic start value: gain rounded to f fractional bits
    function automatic logic [63:0] cordic_x0(input int f);
        return (((64'(GAIN_Q30) << 1) >> (30 - f)) + 64'd1) >> 1;
    endfunction

    // round a q30 product and clamp to the signed 33-bit output range
    function automatic logic [32:0] sat_q30(input logic signed [64:0] p);
        logic signed [34:0] t;
        logic [32:0] r;
        t = 35'((p + 65'sd536870912) >>> 30);
        if (t > 35'sd4294967295)
            r = 33'h0_FFFF_FFFF;
        else if (t < -35'sd4294967296)
            r = 33'h1_0000_0000;
        else
            r = t[32:0];
        return r;
    endfunction

    // round a q30 product and clamp to the unsigned 33-bit range
    function automatic logic [32:0] sat_dist(input logic [63:0] p);
        logic [64:0] s;
        logic [34:0] t;
        logic [32:0] r;
        s = {1'b0, p} + 65'd536870912;
        t = s[64:30];
        if (t > 35'd8589934591)
            r = 33'h1_FFFF_FFFF;
        else
            r = t[32:0];
        return r;
    endfunction

endpackage

// ===== design/lfed_fifo.sv =====
// small register queue used between the front part, the back part and the result side
module lfed_fifo #(
    parameter int WIDTH = lfed_pkg::ITEM_W,
    parameter int DEPTH = lfed_pkg::MID_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic do_wr, do_rd;

    assign full    = (cnt_reg == (AW + 1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW + 1)'(do_wr) - (AW + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== design/lfed_front.sv =====
// front part: takes a position pair, forms the offsets and the mean latitude
module lfed_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [30:0]  first_lat,
    input  logic signed [31:0]  first_lon,
    input  logic signed [30:0]  second_lat,
    input  logic signed [31:0]  second_lon,
    input  logic                q_full,
    output logic                q_push,
    output lfed_pkg::item_t     q_item
);
    logic fv_reg, fv_next;
    lfed_pkg::item_t item_reg, item_next;
    logic signed [33:0] dlon_raw, dlon_w;
    logic signed [31:0] sum, adj, mean, amean_s;
    logic take;

    assign full   = fv_reg && q_full;
    assign take   = push && !full;
    assign q_push = fv_reg && !q_full;
    assign q_item = item_reg;

    always_comb
    begin
        dlon_raw = 34'(second_lon) - 34'(first_lon);
        dlon_w   = dlon_raw;
        // wrap across the date line only when the longitudes straddle it
        if (first_lon[31] != second_lon[31])
        begin
            if (dlon_raw > 34'sd1800000000)
                dlon_w = dlon_raw - 34'sd3600000000;
            else if (dlon_raw < -34'sd1800000000)
                dlon_w = dlon_raw + 34'sd3600000000;
        end
        sum     = 32'(first_lat) + 32'(second_lat);
        adj     = sum[31] ? 32'sd1 : 32'sd0;
        mean    = (sum + adj) >>> 1;
        amean_s = mean[31] ? -mean : mean;
        item_next.dlat   = 32'(second_lat) - 32'(first_lat);
        item_next.dlon   = dlon_w[31:0];
        item_next.amean  = amean_s[30:0];
        item_next.beyond = (amean_s > 32'(lfed_pkg::QUARTER_TURN));
        fv_next = fv_reg;
        if (!full)
            fv_next = push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end
endmodule

// ===== design/lfed_cordic.sv =====
// unrolled cordic: one rotation per stage, cosine of the mean latitude in degrees
module lfed_cordic #(
    parameter int COS_FRAC_BITS = lfed_pkg::COS_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  lfed_pkg::item_t               in_item,
    output logic                          out_valid,
    output lfed_pkg::item_t               out_item,
    output logic signed [COS_FRAC_BITS+2:0] x_out
);
    localparam int XW = COS_FRAC_BITS + 3;
    localparam int NS = COS_FRAC_BITS;
    localparam logic signed [XW-1:0] X0 = XW'(lfed_pkg::cordic_x0(COS_FRAC_BITS));

    logic signed [XW-1:0] x_reg [0:NS-1];
    logic signed [XW-1:0] y_reg [0:NS-1];
    logic signed [31:0]   z_reg [0:NS-1];
    logic                 vld_reg [0:NS-1];
    lfed_pkg::item_t      itm_reg [0:NS-1];

    for (genvar i = 0; i < NS; i++)
    begin : g_it
        localparam logic signed [31:0] ATAN = lfed_pkg::atan_deg7(i);
        logic signed [XW-1:0] xi, yi, dx, dy;
        logic signed [31:0]   zi;
        logic                 vi;
        lfed_pkg::item_t      ii;
        if (i == 0)
        begin : g_src
            assign xi = X0;
            assign yi = '0;
            assign zi = {1'b0, in_item.amean};
            assign vi = in_valid;
            assign ii = in_item;
        end
        else
        begin : g_src
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign vi = vld_reg[i-1];
            assign ii = itm_reg[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                itm_reg[i] <= ii;
                if (!zi[31])
                begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                    z_reg[i] <= zi - ATAN;
                end
                else
                begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                    z_reg[i] <= zi + ATAN;
                end
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_item  = itm_reg[NS-1];
    assign x_out     = x_reg[NS-1];
endmodule

// ===== design/lfed_sqrt.sv =====
// pipelined square root, one result bit per stage, rounded to nearest at the end
module lfed_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [63:0]                 radicand,
    input  logic [lfed_pkg::TAG_W-1:0]  in_tag,
    output logic                        out_valid,
    output logic [31:0]                 root,
    output logic [lfed_pkg::TAG_W-1:0]  out_tag
);
    localparam int NI = 32;

    logic [63:0] r_reg   [0:NI-1];
    logic [63:0] rem_reg [0:NI-1];
    logic        vld_reg [0:NI-1];
    logic [lfed_pkg::TAG_W-1:0] tag_reg [0:NI-1];
    logic        vo_reg;
    logic [31:0] root_reg;
    logic [lfed_pkg::TAG_W-1:0] tago_reg;

    for (genvar i = 0; i < NI; i++)
    begin : g_st
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] ri, remi, trial;
        logic        vi;
        logic [lfed_pkg::TAG_W-1:0] ti;
        if (i == 0)
        begin : g_src
            assign ri   = '0;
            assign remi = radicand;
            assign vi   = in_valid;
            assign ti   = in_tag;
        end
        else
        begin : g_src
            assign ri   = r_reg[i-1];
            assign remi = rem_reg[i-1];
            assign vi   = vld_reg[i-1];
            assign ti   = tag_reg[i-1];
        end
        assign trial = ri + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[i] <= ti;
                if (remi >= trial)
                begin
                    rem_reg[i] <= remi - trial;
                    r_reg[i]   <= (ri >> 1) + BIT;
                end
                else
                begin
                    rem_reg[i] <= remi;
                    r_reg[i]   <= ri >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vld_reg[NI-1];
    end

    // round up when the remainder exceeds the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tago_reg <= tag_reg[NI-1];
            root_reg <= 32'(r_reg[NI-1] + 64'(rem_reg[NI-1] > r_reg[NI-1]));
        end
    end

    assign out_valid = vo_reg;
    assign root      = root_reg;
    assign out_tag   = tago_reg;
endmodule

// ===== design/latlon_flat_earth_distance.sv =====
// top level: flat-earth north/east offset and distance between two positions
// throughput: one pair per cycle while no stall holds the back pipeline, set by the
// unrolled cordic and square-root pipelines
// a full result queue stalls the whole back pipeline; the front queue absorbs input
// reset (async, active low) empties all queues and loads the scale register default
`include "latlon_flat_earth_distance_macros.svh"
module latlon_flat_earth_distance #(
    parameter int COS_FRAC_BITS = lfed_pkg::COS_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [30:0] first_lat,
    input  logic signed [31:0] first_lon,
    input  logic signed [30:0] second_lat,
    input  logic signed [31:0] second_lon,
    output logic               empty,
    input  logic               pop,
    output logic signed [32:0] north_cm,
    output logic signed [32:0] east_cm,
    output logic [32:0]        distance_cm,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);
    localparam int XW = COS_FRAC_BITS + 3;
    localparam int CW = COS_FRAC_BITS + 1;
    localparam int PW = COS_FRAC_BITS + 34;
    localparam longint ONE_L = longint'(1) << COS_FRAC_BITS;
    localparam longint LO_L = (ONE_L + 50) / 100;
    localparam logic signed [XW-1:0] LO_X = XW'(LO_L);
    localparam logic signed [XW-1:0] ONE_X = XW'(ONE_L);

    logic [31:0] cfg_reg;

    logic f_push, mid_full, mid_empty, mid_pop, adv;
    lfed_pkg::item_t f_item, m_item, c_item;
    logic [lfed_pkg::ITEM_W-1:0] m_data;

    logic c_valid;
    logic signed [XW-1:0] c_x;
    logic [CW-1:0] cosc;

    logic vm_reg, ve_reg, vp_reg, vq_reg, vd_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0] dlat_m_reg, dlat_e_reg, e_reg;
    logic signed [64:0] ns_reg, es_reg;
    logic signed [63:0] sq_reg, eq_reg;
    logic [32:0] north_reg, east_reg;
    logic [63:0] sum_reg, dp_reg;
    logic [lfed_pkg::TAG_W-1:0] s_tag, d_tag_reg;
    logic s_valid;
    logic [31:0] s_root;

    logic ofull, opush, opop;
    logic [lfed_pkg::RES_W-1:0] o_wdata, o_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= lfed_pkg::CM_RESET;
        else if (cfg_wr_en)
            cfg_reg <= cfg_wr_data;
    end

    lfed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .first_lat  (first_lat),
        .first_lon  (first_lon),
        .second_lat (second_lat),
        .second_lon (second_lon),
        .q_full     (mid_full),
        .q_push     (f_push),
        .q_item     (f_item)
    );

    lfed_fifo #(
        .WIDTH (lfed_pkg::ITEM_W),
        .DEPTH (lfed_pkg::MID_DEPTH)
    ) u_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_item),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (m_data),
        .empty   (mid_empty)
    );

    assign m_item  = lfed_pkg::item_t'(m_data);
    // the back pipeline moves as one unless a finished result cannot enter the queue
    assign adv     = !(vd_reg && ofull);
    assign mid_pop = adv && !mid_empty;

    lfed_cordic #(
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (!mid_empty),
        .in_item   (m_item),
        .out_valid (c_valid),
        .out_item  (c_item),
        .x_out     (c_x)
    );

    always_comb
    begin
        if (c_item.beyond || c_x < LO_X)
            cosc = CW'(LO_L);
        else if (c_x > ONE_X)
            cosc = CW'(ONE_L);
        else
            cosc = c_x[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            ve_reg <= 1'b0;
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (adv)
        begin
            vm_reg <= c_valid;
            ve_reg <= vm_reg;
            vp_reg <= ve_reg;
            vq_reg <= vp_reg;
            vd_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= PW'(c_item.dlon) * PW'($signed({1'b0, cosc}));
            dlat_m_reg <= c_item.dlat;
            e_reg      <= 32'((prod_reg + PW'(ONE_L >> 1)) >>> COS_FRAC_BITS);
            dlat_e_reg <= dlat_m_reg;
            ns_reg     <= 65'(dlat_e_reg) * 65'($signed({1'b0, cfg_reg}));
            es_reg     <= 65'(e_reg) * 65'($signed({1'b0, cfg_reg}));
            sq_reg     <= 64'(dlat_e_reg) * 64'(dlat_e_reg);
            eq_reg     <= 64'(e_reg) * 64'(e_reg);
            north_reg  <= lfed_pkg::sat_q30(ns_reg);
            east_reg   <= lfed_pkg::sat_q30(es_reg);
            sum_reg    <= sq_reg + eq_reg;
            dp_reg     <= 64'(s_root) * 64'(cfg_reg);
            d_tag_reg  <= s_tag;
        end
    end

    lfed_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vq_reg),
        .radicand  (sum_reg),
        .in_tag    ({north_reg, east_reg}),
        .out_valid (s_valid),
        .root      (s_root),
        .out_tag   (s_tag)
    );

    assign opush   = vd_reg && !ofull;
    assign opop    = pop && !empty;
    assign o_wdata = {d_tag_reg, lfed_pkg::sat_dist(dp_reg)};

    lfed_fifo #(
        .WIDTH (lfed_pkg::RES_W),
        .DEPTH (lfed_pkg::OUT_DEPTH)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (opush),
        .wr_data (o_wdata),
        .full    (ofull),
        .rd_en   (opop),
        .rd_data (o_rdata),
        .empty   (empty)
    );

    assign north_cm    = $signed(o_rdata[98:66]);
    assign east_cm     = $signed(o_rdata[65:33]);
    assign distance_cm = o_rdata[32:0];

    `LFED_ASSERT_NXT(a_stall_holds, vd_reg && ofull && !opop, vd_reg && $stable(dp_reg))
    `LFED_ASSERT_IMP(a_cos_range, c_valid, cosc >= CW'(LO_L) && cosc <= CW'(ONE_L))
    `LFED_ASSERT_NXT(a_result_shown, opush, !empty)
endmodule

// ===== dv/latlon_flat_earth_distance_checker.sv =====
// checker: watches both queue ports, predicts offsets and distance, compares
module latlon_flat_earth_distance_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [30:0] first_lat,
    input  logic signed [31:0] first_lon,
    input  logic signed [30:0] second_lat,
    input  logic signed [31:0] second_lon,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [32:0] north_cm,
    input  logic signed [32:0] east_cm,
    input  logic [32:0]        distance_cm,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output int                 errors,
    output int                 pending
);
    localparam int FRAC = lfed_pkg::COS_FRAC_BITS_DEF;

    typedef struct packed {
        logic [32:0] north;
        logic [32:0] east;
        logic [32:0] distance;
    } offset_t;

    offset_t expected_offsets[$];
    logic [31:0] scale_q30;

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sat_span(input longint v);
        if (v > 64'sd4294967295)
            return 64'sd4294967295;
        if (v < -64'sd4294967296)
            return -64'sd4294967296;
        return v;
    endfunction

    function automatic longint cordic_cos(input longint mean);
        longint unit_val, floor_val, a, x, y, z, dx, dy;
        longint atan_tbl[18];
        unit_val = longint'(1) << FRAC;
        floor_val = (unit_val + 50) / 100;
        atan_tbl = '{450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
                     8951737, 4476142, 2238105, 1119057, 559529, 279765, 139882,
                     69941, 34971, 17485, 8743, 4371};
        a = (mean < 0) ? -mean : mean;
        if (a > 900000000)
            return floor_val;
        x = (((longint'(652032874) << 1) >>> (30 - FRAC)) + 1) >>> 1;
        y = 0;
        z = a;
        for (int i = 0; i < FRAC; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tbl[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_tbl[i];
            end
        end
        if (x < floor_val) x = floor_val;
        if (x > unit_val) x = unit_val;
        return x;
    endfunction

    function automatic longint unsigned root_rounded(input longint unsigned v);
        longint unsigned r, b, rem;
        r = 0;
        b = 64'd1 << 62;
        rem = v;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (rem > r) r++;
        return r;
    endfunction

    function automatic offset_t predict_offsets(input longint lat1, input longint lon1,
                                                input longint lat2, input longint lon2,
                                                input logic [31:0] s);
        longint dlat, dlon, c, e;
        longint unsigned d, dist_cm;
        offset_t r;
        dlat = lat2 - lat1;
        dlon = lon2 - lon1;
        // wrap only when the longitudes straddle zero
        if ((lon1 < 0) != (lon2 < 0))
        begin
            if (dlon > 64'sd1800000000) dlon -= 64'sd3600000000;
            else if (dlon < -64'sd1800000000) dlon += 64'sd3600000000;
        end
        c = cordic_cos((lat1 + lat2) / 2);
        e = floor_shift(dlon * c + (longint'(1) << (FRAC - 1)), FRAC);
        r.north = 33'(sat_span(floor_shift(dlat * longint'(s) + (64'sd1 << 29), 30)));
        r.east = 33'(sat_span(floor_shift(e * longint'(s) + (64'sd1 << 29), 30)));
        d = root_rounded(longint'(dlat * dlat) + longint'(e * e));
        dist_cm = (d * longint'(s) + (64'd1 << 29)) >> 30;
        if (dist_cm > 64'd8589934591) dist_cm = 64'd8589934591;
        r.distance = dist_cm[32:0];
        return r;
    endfunction

    assign pending = expected_offsets.size();

    always @(posedge clk or negedge rst_n)
    begin
        offset_t want;
        if (!rst_n)
        begin
            scale_q30 <= lfed_pkg::CM_RESET;
            expected_offsets.delete();
            errors <= 0;
        end
        else
        begin
            // result side first so a same-cycle transfer on both ends stays ordered
            if (pop && !empty)
            begin
                if (expected_offsets.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_offsets.pop_front();
                    if (want.north !== north_cm)
                    begin
                        $error("north_cm expected %0d actual %0d",
                               $signed(want.north), north_cm);
                        errors <= errors + 1;
                    end
                    if (want.east !== east_cm)
                    begin
                        $error("east_cm expected %0d actual %0d",
                               $signed(want.east), east_cm);
                        errors <= errors + 1;
                    end
                    if (want.distance !== distance_cm)
                    begin
                        $error("distance_cm expected %0d actual %0d",
                               want.distance, distance_cm);
                        errors <= errors + 1;
                    end
                end
            end
            if (push && !full)
                expected_offsets.push_back(predict_offsets(first_lat, first_lon,
                                                           second_lat, second_lon,
                                                           scale_q30));
            if (cfg_wr_en)
                scale_q30 <= cfg_wr_data;
        end
    end
endmodule

// ===== dv/tb_latlon_flat_earth_distance.sv =====
// testbench top: stimulus for the flat-earth distance block and final verdict
module tb_latlon_flat_earth_distance;
    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [30:0] first_lat;
    logic signed [31:0] first_lon;
    logic signed [30:0] second_lat;
    logic signed [31:0] second_lon;
    logic               empty;
    logic               pop;
    logic signed [32:0] north_cm;
    logic signed [32:0] east_cm;
    logic [32:0]        distance_cm;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    int                 errors;
    int                 pending;

    latlon_flat_earth_distance dut (.*);

    latlon_flat_earth_distance_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stall before each transfer, with quiet stretches
    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic send_pair(input logic [30:0] la1, input logic [31:0] lo1,
                             input logic [30:0] la2, input logic [31:0] lo2,
                             input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        first_lat <= la1;
        first_lon <= lo1;
        second_lat <= la2;
        second_lon <= lo2;
        do @(posedge clk); while (full);
    endtask

    task automatic write_scale(input logic [31:0] v);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [30:0] rand_lat();
        case ($urandom_range(0, 5))
            0: return 31'($urandom);
            1: return 31'(int'($urandom_range(0, 1800000000)) - 900000000);
            2: return 31'(int'($urandom_range(0, 2000)) - 1000);
            default: return 31'(int'($urandom_range(0, 1600000000)) - 800000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_lon();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 2000)) + 1799999000);
            2: return 32'(-int'($urandom_range(0, 2000)) - 1799999000);
            default: return 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
        endcase
    endfunction

    initial
    begin
        logic [30:0] la;
        logic [31:0] lo;
        logic [31:0] scales[5];
        rst_n = 1'b0;
        push = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        first_lat = '0;
        first_lon = '0;
        second_lat = '0;
        second_lon = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, wrap across the date line, same sign, beyond-pole mean
        send_pair(31'sd0, 32'sd0, 31'sd0, 32'sd0, 1'b0);
        send_pair(-31'sd900000000, -32'sd1800000000, 31'sd900000000, 32'sd1800000000, 1'b0);
        send_pair(31'sd900000000, 32'sd1800000000, -31'sd900000000, -32'sd1800000000, 1'b0);
        send_pair(31'sd0, 32'sd1799999990, 31'sd0, -32'sd1799999990, 1'b0);
        send_pair(31'sd0, -32'sd1799999990, 31'sd0, 32'sd1799999990, 1'b0);
        send_pair(31'sd450000000, 32'sd100, 31'sd450000000, 32'sd1000000000, 1'b0);
        send_pair(31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1000, 1'b0);
        send_pair(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h3FFF_FFFF, 32'h8000_0000, 1'b1);
        send_pair(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_pair(31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0000, 32'h0000_0001, 1'b1);
        send_pair(31'sd950000000, 32'sd10, 31'sd950000000, 32'sd500000, 1'b1);
        send_pair(-31'sd123456789, 32'sd12345, 31'sd123456789, -32'sd54321, 1'b1);
        send_pair(31'sd1, 32'sd1, -31'sd1, -32'sd1, 1'b1);
        scales = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
                   lfed_pkg::CM_RESET};
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
                write_scale(phase == 5 ? $urandom : scales[phase - 1]);
            repeat (330)
            begin
                la = rand_lat();
                lo = rand_lon();
                // mostly nearby points, sometimes unrelated ones
                if ($urandom_range(0, 2) == 0)
                    send_pair(la, lo, rand_lat(), rand_lon(), 1'($urandom_range(0, 1)));
                else
                    send_pair(la, lo, la + 31'(int'($urandom_range(0, 200000)) - 100000),
                              lo + 32'(int'($urandom_range(0, 200000)) - 100000),
                              1'($urandom_range(0, 1)));
            end
        end
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/lfed_pkg.sv
design/lfed_fifo.sv
design/lfed_front.sv
design/lfed_cordic.sv
design/lfed_sqrt.sv
design/latlon_flat_earth_distance.sv
dv/latlon_flat_earth_distance_checker.sv
dv/tb_latlon_flat_earth_distance.sv
